>>> rtl/xsrb_pkg.sv
// Shared types and fixed field widths for the XOR sprite row blitter.
package xsrb_pkg;

   // Fixed widths of the item fields.
   localparam int ROW_BITS     = 64;
   localparam int SPRITE_BITS  = 8;
   localparam int KIND_BITS    = 2;
   localparam int X_BITS       = 8;
   localparam int ROW_IDX_BITS = 6;

   // Operation codes carried in the kind field; the unused code behaves as a read.
   typedef enum logic [KIND_BITS-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_DRAW  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

endpackage

>>> rtl/xsrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module xsrb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read and a write to the same address in one cycle return the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/xsrb_blit.sv
// Places one sprite byte into a display row at a column, wrapping at the row width.
module xsrb_blit #(
   parameter int DISPLAY_WIDTH = 64
) (
   input  logic [DISPLAY_WIDTH-1:0]         row_in,
   input  logic [xsrb_pkg::SPRITE_BITS-1:0] sprite_byte,
   input  logic [$clog2(DISPLAY_WIDTH)-1:0] x_col,
   output logic [DISPLAY_WIDTH-1:0]         row_out
);

   localparam int ColW = $clog2(DISPLAY_WIDTH);
   localparam int SumW = ColW + 1;

   logic [DISPLAY_WIDTH-1:0] pixel_mask;

   // Column c of the row sits in bit (width - 1 - c). Each sprite pixel lands on
   // its own column, since the row is wider than the sprite.
   always_comb begin
      logic [SumW-1:0] col_sum;
      logic [SumW-1:0] bit_pos;
      pixel_mask = '0;
      col_sum    = '0;
      bit_pos    = '0;
      for (int i = 0; i < xsrb_pkg::SPRITE_BITS; i++) begin
         col_sum = {1'b0, x_col} + SumW'(i);
         if (col_sum >= SumW'(DISPLAY_WIDTH)) begin
            col_sum = col_sum - SumW'(DISPLAY_WIDTH);
         end
         bit_pos = SumW'(DISPLAY_WIDTH - 1) - col_sum;
         pixel_mask[bit_pos[ColW-1:0]] = sprite_byte[xsrb_pkg::SPRITE_BITS-1-i];
      end
   end

   assign row_out = row_in ^ pixel_mask;

endmodule

>>> rtl/xor_sprite_row_blitter.sv
// A word enters the input stage at its accept edge and then the result register, from which its result strobes.
// Throughput: one word per cycle; busy stays low, and the receiver cannot stall the result strobe.
// The limit is the row store's single registered read port; a forwarding register covers a
// draw to the same row in the cycle just before, so back-to-back words on one row are exact.
// Reset (synchronous) clears the pipeline and the per-row valid bits directly; no sweep runs.
// Clear is done the same way: the valid bits drop at once and stale rows read as zero.
module xor_sprite_row_blitter #(
   parameter int DISPLAY_WIDTH  = 64,
   parameter int DISPLAY_HEIGHT = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [xsrb_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [xsrb_pkg::SPRITE_BITS-1:0]    req_sprite_byte,
   input  logic [xsrb_pkg::X_BITS-1:0]         req_x_pos,
   input  logic [xsrb_pkg::ROW_IDX_BITS-1:0]   req_row_index,
   output logic                                rsp_strobe,
   output logic [xsrb_pkg::ROW_BITS-1:0]       rsp_row_bits,
   output logic                                rsp_row_valid
);

   localparam int RowBits  = xsrb_pkg::ROW_BITS;
   localparam int ColW     = $clog2(DISPLAY_WIDTH);
   localparam int RowAw    = $clog2(DISPLAY_HEIGHT);
   localparam int IdxExtW  = xsrb_pkg::ROW_IDX_BITS + 1;
   // The column remainder works on a value that holds sixteen row widths, which covers
   // every x position because the width is at least sixteen.
   localparam int XRemW    = ColW + 4;
   localparam int PadBits  = RowBits - DISPLAY_WIDTH;

   // Input stage.
   logic                               accept;
   logic [XRemW-1:0]                   x_rem;
   logic                               in_range;
   logic                               s1_vld_ff;
   xsrb_pkg::kind_type                 s1_kind_ff;
   logic [xsrb_pkg::SPRITE_BITS-1:0]   s1_sprite_ff;
   logic [ColW-1:0]                    s1_x_ff;
   logic [RowAw-1:0]                   s1_row_ff;
   logic                               s1_in_range_ff;

   // Row store, its valid bits and the forwarding register.
   logic [DISPLAY_WIDTH-1:0]           ram_q;
   logic [DISPLAY_HEIGHT-1:0]          rowv_ff;
   logic [DISPLAY_HEIGHT-1:0]          rowv_in;
   logic                               fwd_vld_ff;
   logic [RowAw-1:0]                   fwd_row_ff;
   logic [DISPLAY_WIDTH-1:0]           fwd_data_ff;

   // Modify stage.
   logic [DISPLAY_WIDTH-1:0]           base_row;
   logic [DISPLAY_WIDTH-1:0]           drawn_row;
   logic                               wr_en;
   logic                               clear_all;
   logic [DISPLAY_WIDTH-1:0]           rsp_row_in;

   // Result register.
   logic                               rsp_strobe_ff;
   logic [DISPLAY_WIDTH-1:0]           rsp_row_ff;
   logic                               rsp_row_valid_ff;

   // Every word finishes in a fixed two-stage pass, so the block never refuses one.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // x modulo the width by four conditional subtractions of the width times eight,
   // four, two and one.
   always_comb begin
      x_rem = XRemW'(req_x_pos);
      for (int k = 3; k >= 0; k--) begin
         if (x_rem >= XRemW'(DISPLAY_WIDTH << k)) begin
            x_rem = x_rem - XRemW'(DISPLAY_WIDTH << k);
         end
      end
   end

   assign in_range = {1'b0, req_row_index} < IdxExtW'(DISPLAY_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= xsrb_pkg::kind_type'(req_kind);
         s1_sprite_ff   <= req_sprite_byte;
         s1_x_ff        <= x_rem[ColW-1:0];
         s1_row_ff      <= req_row_index[RowAw-1:0];
         s1_in_range_ff <= in_range;
      end
   end

   // The row is read at the accept edge, in parallel with the write of the word ahead.
   xsrb_ram #(
      .WIDTH (DISPLAY_WIDTH),
      .DEPTH (DISPLAY_HEIGHT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_row_ff),
      .wr_data (drawn_row),
      .rd_en   (accept),
      .rd_addr (req_row_index[RowAw-1:0]),
      .rd_data (ram_q)
   );

   // The RAM returns the old word when the word ahead wrote the same row at the same
   // edge, so that write is taken from the forwarding register. A row whose valid bit
   // is low has not been drawn since the last clear and reads as zero.
   always_comb begin
      if (fwd_vld_ff && (fwd_row_ff == s1_row_ff)) begin
         base_row = fwd_data_ff;
      end else if (s1_in_range_ff && rowv_ff[s1_row_ff]) begin
         base_row = ram_q;
      end else begin
         base_row = '0;
      end
   end

   xsrb_blit #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH)
   ) u_blit (
      .row_in      (base_row),
      .sprite_byte (s1_sprite_ff),
      .x_col       (s1_x_ff),
      .row_out     (drawn_row)
   );

   // A clear answers with zero for the addressed row; a draw answers with the new row;
   // a read, and the unused code, answer with the stored row. Rows outside the display
   // answer with zero; a draw to one changes nothing, but a clear still clears every row.
   always_comb begin
      rsp_row_in = '0;
      wr_en      = 1'b0;
      clear_all  = 1'b0;
      case (s1_kind_ff)
         xsrb_pkg::KIND_CLEAR: begin
            clear_all = s1_vld_ff;
         end
         xsrb_pkg::KIND_DRAW: begin
            wr_en = s1_vld_ff && s1_in_range_ff;
            if (s1_in_range_ff) begin
               rsp_row_in = drawn_row;
            end
         end
         default: begin
            if (s1_in_range_ff) begin
               rsp_row_in = base_row;
            end
         end
      endcase
   end

   always_comb begin
      rowv_in = rowv_ff;
      if (clear_all) begin
         rowv_in = '0;
      end else if (wr_en) begin
         rowv_in[s1_row_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rowv_ff       <= '0;
         fwd_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rowv_ff       <= rowv_in;
         fwd_vld_ff    <= wr_en;
         rsp_strobe_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      fwd_row_ff       <= s1_row_ff;
      fwd_data_ff      <= drawn_row;
      rsp_row_ff       <= rsp_row_in;
      rsp_row_valid_ff <= s1_in_range_ff;
   end

   // Column 0 goes to the top bit of the result word; bits past the width are zero.
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_row_bits  = RowBits'(rsp_row_ff) << PadBits;
   assign rsp_row_valid = rsp_row_valid_ff;

endmodule

>>> rtl/xsrb_checker.sv
// Port-level checks for the XOR sprite row blitter, bound to the top level.
module xsrb_checker #(
   parameter int DISPLAY_WIDTH  = 64,
   parameter int DISPLAY_HEIGHT = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [xsrb_pkg::KIND_BITS-1:0]    req_kind,
   input logic [xsrb_pkg::ROW_IDX_BITS-1:0] req_row_index,
   input logic                              rsp_strobe,
   input logic [xsrb_pkg::ROW_BITS-1:0]     rsp_row_bits,
   input logic                              rsp_row_valid
);

   localparam int IdxExtW = xsrb_pkg::ROW_IDX_BITS + 1;
   localparam logic [xsrb_pkg::ROW_BITS-1:0] PadMask =
      (xsrb_pkg::ROW_BITS'(1) << (xsrb_pkg::ROW_BITS - DISPLAY_WIDTH)) -
      xsrb_pkg::ROW_BITS'(1);

   // Every accepted word produces its result strobe.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted word produced no result");

   // No result appears without an accepted word ahead of it.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, 2))
      else $error("result without an accepted word");

   // The valid flag reflects whether the addressed row lies inside the display.
   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_row_valid == ({1'b0, $past(req_row_index, 2)} < IdxExtW'(DISPLAY_HEIGHT))))
      else $error("row valid flag does not match the row index");

   // A clear answers with an empty row.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_kind, 2) == xsrb_pkg::KIND_CLEAR)) |->
         (rsp_row_bits == '0))
      else $error("clear returned a nonzero row");

   // Bits past the display width, and every bit of a row outside the display, are zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (((rsp_row_bits & PadMask) == '0) &&
                      (rsp_row_valid || (rsp_row_bits == '0))))
      else $error("result has pixels outside the display");

endmodule

bind xor_sprite_row_blitter xsrb_checker #(
   .DISPLAY_WIDTH  (DISPLAY_WIDTH),
   .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
) u_xsrb_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for the XOR sprite row blitter display store.
module testbench;

   // The block is built with its default display size, so the predictor uses the same.
   localparam int DISPLAY_WIDTH  = 64;
   localparam int DISPLAY_HEIGHT = 32;
   localparam int ROW_AW         = $clog2(DISPLAY_HEIGHT);

   // Field widths taken from the package, used for size casts of random values.
   localparam int SPRITE_W  = xsrb_pkg::SPRITE_BITS;
   localparam int X_W       = xsrb_pkg::X_BITS;
   localparam int ROW_IDX_W = xsrb_pkg::ROW_IDX_BITS;

   // The package names three operations; the fourth code must behave as a read.
   localparam logic [xsrb_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   // Stimulus shape and run limits.
   localparam int RANDOM_WORDS  = 1100;
   localparam int QUIET_TAIL    = 150;
   localparam int DRAIN_EVERY   = 250;
   localparam int IDLE_LIMIT    = 200;
   localparam int SETTLE_CYCLES = 8;

   // One command word as it is handed to the block, plus how the driver presents it:
   // the idle cycles to insert before it and whether to wait for all results first.
   typedef struct {
      logic [xsrb_pkg::KIND_BITS-1:0]    kind;
      logic [xsrb_pkg::SPRITE_BITS-1:0]  sprite;
      logic [xsrb_pkg::X_BITS-1:0]       x;
      logic [xsrb_pkg::ROW_IDX_BITS-1:0] row;
      int                                gap;
      bit                                drain;
   } op_word_type;

   // The row that a command word is expected to report.
   typedef struct {
      logic [xsrb_pkg::ROW_BITS-1:0] bits;
      logic                          valid;
   } row_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic [xsrb_pkg::KIND_BITS-1:0]    req_kind = xsrb_pkg::KIND_READ;
   logic [xsrb_pkg::SPRITE_BITS-1:0]  req_sprite_byte = '0;
   logic [xsrb_pkg::X_BITS-1:0]       req_x_pos = '0;
   logic [xsrb_pkg::ROW_IDX_BITS-1:0] req_row_index = '0;
   logic                              busy;
   logic                              rsp_strobe;
   logic [xsrb_pkg::ROW_BITS-1:0]     rsp_row_bits;
   logic                              rsp_row_valid;

   // Words waiting to be driven, and row results predicted for words already accepted.
   op_word_type    op_words[$];
   row_result_type row_results_due[$];

   // The predictor's own copy of the frame.
   logic [xsrb_pkg::ROW_BITS-1:0] frame_rows [DISPLAY_HEIGHT];

   // Driver state: the word currently held on the request ports and its remaining gap.
   op_word_type held_word;
   bit          word_held = 1'b0;
   int          idle_left = 0;

   int fail_count = 0;
   int idle_cycles = 0;

   xor_sprite_row_blitter #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_sprite_byte (req_sprite_byte),
      .req_x_pos       (req_x_pos),
      .req_row_index   (req_row_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_row_bits    (rsp_row_bits),
      .rsp_row_valid   (rsp_row_valid)
   );

   always #5 clock = ~clock;

   // Applies one command word to the predicted frame and returns the row it reports.
   // A clear zeroes the whole frame, a draw XORs the sprite in with wrap at the right
   // edge, and every other code only reads. Rows past the display height are left
   // alone and report zero with the valid flag low.
   function automatic row_result_type apply_display_op(input op_word_type op);
      row_result_type res;
      int             x_start;
      int             col;
      bit             in_range;
      in_range = op.row < DISPLAY_HEIGHT;
      x_start  = op.x % DISPLAY_WIDTH;
      case (op.kind)
         xsrb_pkg::KIND_CLEAR: begin
            for (int r = 0; r < DISPLAY_HEIGHT; r++) frame_rows[r] = '0;
         end
         xsrb_pkg::KIND_DRAW: begin
            if (in_range) begin
               // Sprite bit 7 lands on the starting column, bit 0 seven columns later.
               for (int i = 0; i < xsrb_pkg::SPRITE_BITS; i++) begin
                  if (op.sprite[xsrb_pkg::SPRITE_BITS-1-i]) begin
                     col = (x_start + i) % DISPLAY_WIDTH;
                     frame_rows[op.row[ROW_AW-1:0]] ^=
                        ({{(xsrb_pkg::ROW_BITS-1){1'b0}}, 1'b1} <<
                         (xsrb_pkg::ROW_BITS-1-col));
                  end
               end
            end
         end
         default: ;
      endcase
      res.valid = in_range;
      res.bits  = '0;
      if (in_range) res.bits = frame_rows[op.row[ROW_AW-1:0]];
      return res;
   endfunction

   // Picks an operation: mostly draws and reads, with the odd clear so that the frame
   // keeps a lot of content, and some words with the unused code.
   function automatic logic [xsrb_pkg::KIND_BITS-1:0] pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return xsrb_pkg::KIND_CLEAR;
      if (roll < 60) return xsrb_pkg::KIND_DRAW;
      if (roll < 92) return xsrb_pkg::KIND_READ;
      return KIND_UNUSED;
   endfunction

   // Rows are mostly inside the display; about one in seven falls past its height.
   function automatic logic [xsrb_pkg::ROW_IDX_BITS-1:0] pick_row();
      if ($urandom_range(6) == 0) return ROW_IDX_W'($urandom_range(DISPLAY_HEIGHT, 63));
      return ROW_IDX_W'($urandom_range(0, DISPLAY_HEIGHT - 1));
   endfunction

   task automatic push_word(input logic [xsrb_pkg::KIND_BITS-1:0] kind,
                            input logic [xsrb_pkg::SPRITE_BITS-1:0] sprite,
                            input logic [xsrb_pkg::X_BITS-1:0] x,
                            input logic [xsrb_pkg::ROW_IDX_BITS-1:0] row,
                            input int gap, input bit drain);
      op_word_type w;
      w.kind   = kind;
      w.sprite = sprite;
      w.x      = x;
      w.row    = row;
      w.gap    = gap;
      w.drain  = drain;
      op_words.push_back(w);
   endtask

   // Driver. A word is accepted at an edge where start is high and busy is low; its
   // expected row is computed right then, so the predicted frame follows the order
   // in which the block takes the words. The next word is loaded in the same edge, so
   // back-to-back words keep start high without a glitch. The driver holds start low
   // for the word's gap, and a drain word also waits until every result has arrived.
   always @(posedge clock) begin
      logic next_start;
      next_start = 1'b0;
      if (reset) begin
         word_held = 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            row_results_due.push_back(apply_display_op(held_word));
            word_held = 1'b0;
         end
         if (!word_held && op_words.size() > 0) begin
            held_word = op_words.pop_front();
            word_held = 1'b1;
            idle_left = held_word.gap;
         end
         if (word_held) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (!(held_word.drain && row_results_due.size() != 0)) begin
               next_start = 1'b1;
               req_kind        <= held_word.kind;
               req_sprite_byte <= held_word.sprite;
               req_x_pos       <= held_word.x;
               req_row_index   <= held_word.row;
            end
         end
      end
      start <= next_start;
   end

   // Monitor. The strobe marks a result for exactly one cycle, and it is compared field
   // by field against the oldest outstanding prediction.
   always @(posedge clock) begin
      row_result_type due;
      if (!reset && rsp_strobe) begin
         if (row_results_due.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual bits %h valid %b",
                     $time, rsp_row_bits, rsp_row_valid);
            fail_count++;
         end else begin
            due = row_results_due.pop_front();
            if (rsp_row_bits !== due.bits) begin
               $display("%0t: row_bits mismatch: expected %h, actual %h",
                        $time, due.bits, rsp_row_bits);
               fail_count++;
            end
            if (rsp_row_valid !== due.valid) begin
               $display("%0t: row_valid mismatch: expected %b, actual %b",
                        $time, due.valid, rsp_row_valid);
               fail_count++;
            end
         end
      end
   end

   // Watchdog. Any cycle that moves a word in either direction restarts the count; the
   // longest legal quiet stretch is the largest gap plus the pipeline passage of a word.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int  produced;
      int  next_drain;
      int  burst_len;
      int  gap;
      bit  quiet;
      bit  gappy;
      bit  drain;
      logic [xsrb_pkg::ROW_IDX_BITS-1:0] burst_row;

      for (int r = 0; r < DISPLAY_HEIGHT; r++) frame_rows[r] = '0;

      // Directed part, all back to back. Reads right after reset must see an empty
      // frame, including the last row and a row past the display height.
      push_word(xsrb_pkg::KIND_READ,  8'h00, 8'h00, 6'd0,  0, 1'b0);
      push_word(xsrb_pkg::KIND_READ,  8'hff, 8'hff, 6'd31, 0, 1'b0);
      push_word(xsrb_pkg::KIND_READ,  8'h00, 8'h00, 6'd63, 0, 1'b0);
      // Full sprite at the left edge, then one that wraps past the right edge.
      push_word(xsrb_pkg::KIND_DRAW,  8'hff, 8'h00, 6'd0,  0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'hff, 8'd60, 6'd1,  0, 1'b0);
      // Columns beyond the width fold back: 255 starts at the last column, 64 at zero.
      push_word(xsrb_pkg::KIND_DRAW,  8'hc3, 8'hff, 6'd2,  0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'h81, 8'd64, 6'd3,  0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'h00, 8'd17, 6'd4,  0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'h81, 8'd57, 6'd31, 0, 1'b0);
      // Draws to rows past the height change nothing and report an invalid row.
      push_word(xsrb_pkg::KIND_DRAW,  8'hff, 8'hff, 6'd32, 0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'hff, 8'hff, 6'd63, 0, 1'b0);
      // Consecutive draws to one row exercise the read-after-write path; the second
      // draw of the same sprite cancels the first.
      push_word(xsrb_pkg::KIND_DRAW,  8'ha5, 8'd3,  6'd5,  0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'h5a, 8'd7,  6'd5,  0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'h5a, 8'd7,  6'd5,  0, 1'b0);
      push_word(xsrb_pkg::KIND_READ,  8'h00, 8'h00, 6'd5,  0, 1'b0);
      // The unused code reads the row back.
      push_word(KIND_UNUSED, 8'hff, 8'hff, 6'd0, 0, 1'b0);
      push_word(KIND_UNUSED, 8'h00, 8'h00, 6'd40, 0, 1'b0);
      // Clear on a valid row and on one past the height, then the frame must be empty.
      push_word(xsrb_pkg::KIND_CLEAR, 8'hff, 8'hff, 6'd0,  0, 1'b0);
      push_word(xsrb_pkg::KIND_READ,  8'h00, 8'h00, 6'd1,  0, 1'b0);
      push_word(xsrb_pkg::KIND_DRAW,  8'h3c, 8'd62, 6'd1,  0, 1'b0);
      push_word(xsrb_pkg::KIND_CLEAR, 8'h00, 8'h00, 6'd45, 0, 1'b0);
      push_word(xsrb_pkg::KIND_READ,  8'h00, 8'h00, 6'd1,  0, 1'b0);
      // Draw right after a clear, then read it back once everything is home.
      push_word(xsrb_pkg::KIND_DRAW,  8'h96, 8'd30, 6'd1,  0, 1'b0);
      push_word(xsrb_pkg::KIND_READ,  8'h00, 8'h00, 6'd1,  0, 1'b1);

      // Random part. Segments of a hundred words alternate between bursty idling and
      // none at all; the tail is driven at full rate. About one time in six a short
      // run of words hits a single row so that draws pile up and get read back.
      produced   = 0;
      next_drain = DRAIN_EVERY;
      while (produced < RANDOM_WORDS) begin
         burst_len = ($urandom_range(5) == 0) ? $urandom_range(2, 4) : 1;
         burst_row = pick_row();
         for (int b = 0; b < burst_len; b++) begin
            quiet = produced >= RANDOM_WORDS - QUIET_TAIL;
            gappy = ((produced / 100) % 2) == 0;
            gap   = 0;
            if (!quiet && gappy && $urandom_range(3) == 0) gap = $urandom_range(1, 17);
            drain = produced >= next_drain;
            if (drain) next_drain += DRAIN_EVERY;
            push_word(pick_kind(), SPRITE_W'($urandom_range(255)),
                      X_W'($urandom_range(255)),
                      (burst_len > 1) ? burst_row : pick_row(), gap, drain);
            produced++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait on the falling edge, away from the driver and monitor updates, until every
      // word is in and every predicted row has been seen, then let the pipeline settle.
      do @(negedge clock);
      while (op_words.size() != 0 || word_held || row_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
